FILE: sv/spectrum_bin_peak_decay_smoother_assert.svh
// assertion macros used by the checker of the bin smoother
// expects clk and rst_n in the scope where a macro is used
`ifndef SPECTRUM_BIN_PEAK_DECAY_SMOOTHER_ASSERT_SVH
`define SPECTRUM_BIN_PEAK_DECAY_SMOOTHER_ASSERT_SVH

// same-cycle implication
`define SBPD_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sbpd assertion failed");

// next-cycle implication
`define SBPD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sbpd assertion failed");

`endif

FILE: sv/sbpd_pkg.sv
// shared types and constants of the spectrum bin smoother
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package sbpd_pkg;

    localparam int FFT_SIZE_DEF = 1024;
    localparam int IDX_W        = 10;
    localparam int MAG_W        = 32;
    localparam int SUM_W        = 42;
    localparam int COEF_W       = 16;
    localparam logic [COEF_W-1:0] COEF_RESET = 16'd53740;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_RE,
        ST_MUL_IM,
        ST_SUM,
        ST_ROOT,
        ST_CMP,
        ST_BLEND,
        ST_FINISH
    } state_t;

endpackage

`default_nettype wire

FILE: sv/sbpd_isqrt.sv
// iterative integer square root, one result bit per cycle
// depends on nothing; started by the top level sequencer
`timescale 1ns / 1ps
`default_nettype none

module sbpd_isqrt
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [63:0] radicand,
    output logic      [31:0] root,
    output logic             done
);

    logic [63:0] rad_reg;
    logic [34:0] rem_reg;
    logic [31:0] root_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;

    logic [34:0] rem_shift;
    logic [34:0] trial;
    logic        fits;

    // bring down two radicand bits, try root*4+1
    assign rem_shift = {rem_reg[32:0], rad_reg[63:62]};
    assign trial     = {1'b0, root_reg, 2'b01};
    assign fits      = (rem_shift >= trial);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg <= {rad_reg[61:0], 2'b00};
            if (fits)
            begin
                rem_reg  <= rem_shift - trial;
                root_reg <= {root_reg[30:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_shift;
                root_reg <= {root_reg[30:0], 1'b0};
            end
        end
    end

    assign root = root_reg;
    assign done = done_reg;

endmodule

`default_nettype wire

FILE: sv/spectrum_bin_peak_decay_smoother.sv
// top level of the spectrum bin smoother: sequencer, shared multiplier, bin store
// depends on sbpd_pkg and sbpd_isqrt
//
//  channel   dir   handshake            payload
//  input     in    in_valid/in_ready    bin_real, bin_imag
//  result    out   out_valid/out_ready  bin_index, smoothed_mag, prefix_sum, last_bin
//  config    in    cfg_valid/cfg_ready  cfg_data (release coefficient)
//
// a word passes through squaring of both parts, the sum, the 32 one-bit steps of the
// square root unit, the compare and a blend step when the bin decays; the next word is
// taken the cycle after the result is loaded, while that result may still wait in the
// output register. after reset the bin store reads as zero for the whole first frame,
// with no clearing pass. a stalled result holds the sequencer in its last step.
`timescale 1ns / 1ps
`default_nettype none

module spectrum_bin_peak_decay_smoother
#(
    parameter int FFT_SIZE = sbpd_pkg::FFT_SIZE_DEF
)
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic signed [31:0]               bin_real,
    input  wire logic signed [31:0]               bin_imag,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic [sbpd_pkg::IDX_W-1:0]            bin_index,
    output logic [sbpd_pkg::MAG_W-1:0]            smoothed_mag,
    output logic [sbpd_pkg::SUM_W-1:0]            prefix_sum,
    output logic                                  last_bin,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [sbpd_pkg::COEF_W-1:0]      cfg_data
);

    localparam int NUM_BINS = FFT_SIZE / 2 + 1;
    localparam int CNT_W    = $clog2(NUM_BINS);
    // floor of log2(FFT_SIZE), less two
    localparam int SHIFT    = $clog2(FFT_SIZE + 1) - 3;
    localparam int IDX_W    = sbpd_pkg::IDX_W;
    localparam int SUM_W    = sbpd_pkg::SUM_W;
    localparam logic [CNT_W-1:0] LAST_K = CNT_W'(NUM_BINS - 1);

    sbpd_pkg::state_t state_reg, state_next;

    logic [sbpd_pkg::COEF_W-1:0] coef_reg;
    logic [CNT_W-1:0]            cnt_reg;
    logic                        seen_reg;
    logic [SUM_W-1:0]            total_reg;

    logic [31:0] re_reg;
    logic [31:0] im_reg;
    logic [31:0] rd_reg;
    logic [63:0] prod_reg;
    logic [63:0] acc_reg;
    logic [31:0] mag_reg;
    logic [31:0] s_reg;

    logic                        out_valid_reg;
    logic [IDX_W-1:0]            bin_index_reg;
    logic [31:0]                 smoothed_reg;
    logic [SUM_W-1:0]            prefix_reg;
    logic                        last_reg;

    logic [31:0] smooth_mem [NUM_BINS];

    logic        accept;
    logic        load_out;
    logic        sqrt_start;
    logic [31:0] sqrt_root;
    logic        sqrt_done;
    logic [31:0] re_abs;
    logic [31:0] im_abs;
    logic [31:0] old_val;
    logic [31:0] diff;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] prod_next;
    logic [32:0] blend;
    logic        is_last;
    logic [SUM_W-1:0] total_next;

    assign in_ready  = (state_reg == sbpd_pkg::ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    assign re_abs = bin_real[31] ? (~bin_real + 32'd1) : bin_real;
    assign im_abs = bin_imag[31] ? (~bin_imag + 32'd1) : bin_imag;

    // store entries are only trusted once a full frame has been written
    assign old_val = seen_reg ? rd_reg : 32'd0;
    assign diff    = old_val - mag_reg;
    assign blend   = {1'b0, mag_reg} + {1'b0, prod_reg[47:16]};

    assign is_last    = (cnt_reg == LAST_K);
    assign total_next = (cnt_reg == '0) ? SUM_W'(s_reg) : total_reg + SUM_W'(s_reg);

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        sqrt_start = 1'b0;
        load_out   = 1'b0;
        mul_a      = diff;
        mul_b      = {16'd0, coef_reg};
        unique case (state_reg)
            sbpd_pkg::ST_IDLE:
            begin
                if (accept)
                    state_next = sbpd_pkg::ST_MUL_RE;
            end
            sbpd_pkg::ST_MUL_RE:
            begin
                mul_a      = re_reg;
                mul_b      = re_reg;
                state_next = sbpd_pkg::ST_MUL_IM;
            end
            sbpd_pkg::ST_MUL_IM:
            begin
                mul_a      = im_reg;
                mul_b      = im_reg;
                state_next = sbpd_pkg::ST_SUM;
            end
            sbpd_pkg::ST_SUM:
            begin
                sqrt_start = 1'b1;
                state_next = sbpd_pkg::ST_ROOT;
            end
            sbpd_pkg::ST_ROOT:
            begin
                if (sqrt_done)
                    state_next = sbpd_pkg::ST_CMP;
            end
            sbpd_pkg::ST_CMP:
            begin
                if (mag_reg > old_val)
                    state_next = sbpd_pkg::ST_FINISH;
                else
                    state_next = sbpd_pkg::ST_BLEND;
            end
            sbpd_pkg::ST_BLEND:
            begin
                state_next = sbpd_pkg::ST_FINISH;
            end
            sbpd_pkg::ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    load_out   = 1'b1;
                    state_next = sbpd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sbpd_pkg::ST_IDLE;
            end
        endcase
    end

    assign prod_next = mul_a * mul_b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= sbpd_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg      <= sbpd_pkg::COEF_RESET;
            cnt_reg       <= '0;
            seen_reg      <= 1'b0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                coef_reg <= cfg_data;
            if (load_out)
            begin
                total_reg     <= total_next;
                cnt_reg       <= is_last ? '0 : cnt_reg + 1'b1;
                out_valid_reg <= 1'b1;
                if (is_last)
                    seen_reg <= 1'b1;
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        if (accept)
        begin
            re_reg <= re_abs;
            im_reg <= im_abs;
        end
        if (state_reg == sbpd_pkg::ST_MUL_IM)
            acc_reg <= prod_reg;
        if (state_reg == sbpd_pkg::ST_ROOT && sqrt_done)
            mag_reg <= sqrt_root >> SHIFT;
        if (state_reg == sbpd_pkg::ST_CMP)
            s_reg <= mag_reg;
        if (state_reg == sbpd_pkg::ST_BLEND)
            s_reg <= blend[31:0];
        if (load_out)
        begin
            bin_index_reg <= IDX_W'(cnt_reg);
            smoothed_reg  <= s_reg;
            prefix_reg    <= total_next;
            last_reg      <= is_last;
        end
    end

    // bin store
    always_ff @(posedge clk)
    begin
        if (accept)
            rd_reg <= smooth_mem[cnt_reg];
        if (load_out)
            smooth_mem[cnt_reg] <= s_reg;
    end

    sbpd_isqrt u_isqrt
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (acc_reg + prod_reg),
        .root     (sqrt_root),
        .done     (sqrt_done)
    );

    assign out_valid    = out_valid_reg;
    assign bin_index    = bin_index_reg;
    assign smoothed_mag = smoothed_reg;
    assign prefix_sum   = prefix_reg;
    assign last_bin     = last_reg;

endmodule

`default_nettype wire

FILE: sv/sbpd_checker.sv
// port-level checker for the spectrum bin smoother, bound to the top level
// depends on sbpd_pkg and spectrum_bin_peak_decay_smoother_assert.svh
`timescale 1ns / 1ps
`default_nettype none

`include "spectrum_bin_peak_decay_smoother_assert.svh"

module sbpd_checker
#(
    parameter int FFT_SIZE = sbpd_pkg::FFT_SIZE_DEF
)
(
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          in_valid,
    input wire logic                          in_ready,
    input wire logic                          out_valid,
    input wire logic                          out_ready,
    input wire logic [sbpd_pkg::IDX_W-1:0]    bin_index,
    input wire logic [sbpd_pkg::MAG_W-1:0]    smoothed_mag,
    input wire logic [sbpd_pkg::SUM_W-1:0]    prefix_sum,
    input wire logic                          last_bin
);

    localparam int IDX_W    = sbpd_pkg::IDX_W;
    localparam int SUM_W    = sbpd_pkg::SUM_W;
    localparam int NUM_BINS = FFT_SIZE / 2 + 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_BINS - 1);

    // a stalled result word holds
    `SBPD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
        out_valid && $stable({bin_index, smoothed_mag, prefix_sum, last_bin}))

    // one word at a time through the sequencer
    `SBPD_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

    // the frame restarts the running sum at bin zero
    `SBPD_ASSERT_IMPL(a_sum_restart, out_valid && bin_index == '0,
        prefix_sum == SUM_W'(smoothed_mag))

    // the last flag is only raised on the top bin
    `SBPD_ASSERT_IMPL(a_last_index, out_valid && last_bin, bin_index == LAST_IDX)

endmodule

bind spectrum_bin_peak_decay_smoother sbpd_checker #(.FFT_SIZE(FFT_SIZE)) u_sbpd_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .bin_index    (bin_index),
    .smoothed_mag (smoothed_mag),
    .prefix_sum   (prefix_sum),
    .last_bin     (last_bin)
);

`default_nettype wire
